// ----- rtl/scl_pkg.sv -----
// shared constants, codes and beat types for the streamline chord length unit
// no dependencies; every other file in rtl/ refers to it by scoped names
package scl_pkg;

  localparam int WORD_BITS  = 32;
  localparam int DIFF_W     = WORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int RATIO_W    = PROD_W - 1;
  localparam int DVD_W      = RATIO_W + WORD_BITS;
  localparam int DIV_STEPS  = WORD_BITS;
  localparam int SQ_W       = 2 * WORD_BITS + 1;
  localparam int ROOT_W     = WORD_BITS + 1;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int SQRT_REM_W = ROOT_W + 2;
  localparam int CORNERS    = 4;
  localparam int CUTS       = 2;

  // closing edge of a triangle starts at corner 2
  localparam int TRI_CLOSE_EDGE = 2;

  localparam int CC_W = 3;
  localparam logic [CC_W-1:0] CC_RESET    = 3'd4;
  localparam logic [CC_W-1:0] CC_TRIANGLE = 3'd3;

  // register stages: eight in front, divider, four between, square root, output
  localparam int FRONT_STAGES = 8;
  localparam int MID_STAGES   = 4;
  localparam int NSTAGE       = FRONT_STAGES + DIV_STEPS + MID_STAGES + SQRT_STEPS + 1;

  typedef enum logic [1:0] {
    STATUS_TWO_CUTS = 2'd0,
    STATUS_ZERO_VEL = 2'd1,
    STATUS_NO_CUTS  = 2'd2
  } status_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] corner0_x;
    logic [WORD_BITS-1:0] corner0_y;
    logic [WORD_BITS-1:0] corner1_x;
    logic [WORD_BITS-1:0] corner1_y;
    logic [WORD_BITS-1:0] corner2_x;
    logic [WORD_BITS-1:0] corner2_y;
    logic [WORD_BITS-1:0] corner3_x;
    logic [WORD_BITS-1:0] corner3_y;
    logic [WORD_BITS-1:0] point_x;
    logic [WORD_BITS-1:0] point_y;
    logic [WORD_BITS-1:0] velocity_x;
    logic [WORD_BITS-1:0] velocity_y;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] chord_length;
    status_t              status;
  } out_item_t;

  typedef struct packed {
    logic [CORNERS-1:0][WORD_BITS-1:0] x;
    logic [CORNERS-1:0][WORD_BITS-1:0] y;
    logic [CORNERS-1:0][DIFF_W-1:0]    ex;
    logic [CORNERS-1:0][DIFF_W-1:0]    ey;
    logic                              tri_shape;
    logic                              zero_vel;
  } geo_t;

  typedef struct packed {
    logic                 negx;
    logic                 negy;
    logic [WORD_BITS-1:0] basex;
    logic [WORD_BITS-1:0] basey;
  } cut_side_t;

  typedef struct packed {
    logic [RATIO_W-1:0]   num;
    logic [RATIO_W-1:0]   den;
    logic [WORD_BITS-1:0] absx;
    logic [WORD_BITS-1:0] absy;
    cut_side_t            side;
  } cut_t;

  typedef struct packed {
    cut_side_t [CUTS-1:0] cs;
    status_t              status;
  } div_side_t;

endpackage

// ----- rtl/scl_if.sv -----
// valid/ready channels of the streamline chord length unit
// depends on scl_pkg for the beat types
interface scl_in_if;
  logic              valid;
  logic              ready;
  scl_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scl_out_if;
  logic               valid;
  logic               ready;
  scl_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scl_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [scl_pkg::CC_W-1:0]    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/scl_div.sv -----
// pipelined restoring divider, one quotient bit per stage, plus round-half-up flag
// depends on scl_pkg; the quotient must fit in WORD_BITS (dividend high part < divisor)
module scl_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [scl_pkg::DVD_W-1:0]     dividend,
  input  logic [scl_pkg::RATIO_W-1:0]   divisor,
  output logic [scl_pkg::WORD_BITS-1:0] quotient,
  output logic                          round_up
);

  localparam int W  = scl_pkg::WORD_BITS;
  localparam int RW = scl_pkg::RATIO_W;
  localparam int NS = scl_pkg::DIV_STEPS;

  logic [RW-1:0] rem_q [NS];
  logic [RW-1:0] den_q [NS];
  logic [W-1:0]  low_q [NS];
  logic [W-1:0]  quo_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_step
    logic [RW-1:0] r_in;
    logic [RW-1:0] d_in;
    logic [W-1:0]  l_in;
    logic [W-1:0]  q_in;
    logic [RW:0]   trial;
    logic          take;
    logic [W-1:0]  qbit;

    if (s == 0) begin : g_first
      assign r_in = dividend[scl_pkg::DVD_W-1:W];
      assign l_in = dividend[W-1:0];
      assign d_in = divisor;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[s-1];
      assign l_in = low_q[s-1];
      assign d_in = den_q[s-1];
      assign q_in = quo_q[s-1];
    end

    assign trial = {r_in, l_in[NS-1-s]};
    assign take  = trial >= {1'b0, d_in};
    assign qbit  = {{(W-1){1'b0}}, take} << (NS - 1 - s);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= take ? RW'(trial - {1'b0, d_in}) : trial[RW-1:0];
        den_q[s] <= d_in;
        low_q[s] <= l_in;
        quo_q[s] <= q_in | qbit;
      end
    end
  end

  assign quotient = quo_q[NS-1];
  // ties go up: twice the remainder against the divisor
  assign round_up = {rem_q[NS-1], 1'b0} >= {1'b0, den_q[NS-1]};

endmodule

// ----- rtl/scl_sqrt.sv -----
// pipelined integer square root, one root bit per stage, plus round-to-nearest flag
// depends on scl_pkg
module scl_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [scl_pkg::SQ_W-1:0]    radicand,
  output logic [scl_pkg::ROOT_W-1:0]  root,
  output logic                        round_up
);

  localparam int NS  = scl_pkg::SQRT_STEPS;
  localparam int PW  = 2 * NS;
  localparam int RTW = scl_pkg::ROOT_W;
  localparam int RMW = scl_pkg::SQRT_REM_W;

  logic [PW-1:0]  rad_q  [NS];
  logic [RMW-1:0] rem_q  [NS];
  logic [RTW-1:0] root_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_step
    logic [PW-1:0]  p_in;
    logic [RMW-1:0] r_in;
    logic [RTW-1:0] q_in;
    logic [RMW+1:0] trial;
    logic [RMW+1:0] sub;
    logic           take;

    if (s == 0) begin : g_first
      assign p_in = {{(PW-scl_pkg::SQ_W){1'b0}}, radicand};
      assign r_in = '0;
      assign q_in = '0;
    end else begin : g_next
      assign p_in = rad_q[s-1];
      assign r_in = rem_q[s-1];
      assign q_in = root_q[s-1];
    end

    assign trial = {r_in, p_in[PW-1-2*s -: 2]};
    assign sub   = {2'b00, q_in, 2'b01};
    assign take  = trial >= sub;

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[s]  <= p_in;
        rem_q[s]  <= take ? RMW'(trial - sub) : trial[RMW-1:0];
        root_q[s] <= {q_in[RTW-2:0], take};
      end
    end
  end

  assign root     = root_q[NS-1];
  assign round_up = rem_q[NS-1] > {{(RMW-RTW){1'b0}}, root_q[NS-1]};

endmodule

// ----- rtl/streamline_chord_length_unit.sv -----
// streamline chord length through a triangle or quadrilateral, fully pipelined
// each accepted query beat gives one result beat, in order; one beat per cycle while the result side does not stall
// pipeline depth is dominated by the 32-stage quotient dividers and the 33-stage square root
// any stall on the result side holds every stage; nothing is dropped or repeated
// rst (synchronous) clears all stage valid bits and sets the shape to quadrilateral
// depends on scl_pkg, scl_if, scl_div and scl_sqrt
module streamline_chord_length_unit (
  input  logic     clk,
  input  logic     rst,
  scl_cfg_if.sink  cfg,
  scl_in_if.sink   query,
  scl_out_if.source result
);

  localparam int W  = scl_pkg::WORD_BITS;
  localparam int DW = scl_pkg::DIFF_W;
  localparam int PW = scl_pkg::PROD_W;
  localparam int RW = scl_pkg::RATIO_W;
  localparam int XW = scl_pkg::DVD_W;
  localparam int NC = scl_pkg::CORNERS;
  localparam int NK = scl_pkg::CUTS;
  localparam int NS = scl_pkg::NSTAGE;

  function automatic logic [DW-1:0] sdiff(input logic [W-1:0] a, input logic [W-1:0] b);
    return {a[W-1], a} - {b[W-1], b};
  endfunction

  function automatic logic [W-1:0] mag(input logic [DW-1:0] v);
    return v[DW-1] ? W'(-v) : v[W-1:0];
  endfunction

  function automatic scl_pkg::cut_t make_cut(input logic [RW-1:0] num, input logic [RW-1:0] den,
                                             input logic [DW-1:0] ex, input logic [DW-1:0] ey,
                                             input logic [W-1:0] bx, input logic [W-1:0] by);
    scl_pkg::cut_t c;
    c.num        = num;
    c.den        = den;
    c.absx       = mag(ex);
    c.absy       = mag(ey);
    c.side.negx  = ex[DW-1];
    c.side.negy  = ey[DW-1];
    c.side.basex = bx;
    c.side.basey = by;
    return c;
  endfunction

  // shape register
  logic [scl_pkg::CC_W-1:0] corner_count;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= scl_pkg::CC_RESET;
    end else if (cfg.valid) begin
      corner_count <= cfg.data;
    end
  end

  // stage valid bits, whole pipe holds while the output beat waits
  logic [NS-1:0] vld;
  logic          en;

  assign en           = !vld[NS-1] || result.ready;
  assign query.ready  = en;
  assign result.valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], query.valid};
    end
  end

  // stage A: input register
  scl_pkg::in_item_t a_item;

  always_ff @(posedge clk) begin
    if (en) begin
      a_item <= query.data;
    end
  end

  // stage B: edge vectors and offsets of each edge start from the point
  scl_pkg::geo_t          b_geo_next, b_geo;
  logic [NC-1:0][DW-1:0]  b_rx_next, b_ry_next, b_rx, b_ry;
  logic [W-1:0]           b_vx, b_vy;

  always_comb begin
    int nxt;
    b_geo_next.x = {a_item.corner3_x, a_item.corner2_x, a_item.corner1_x, a_item.corner0_x};
    b_geo_next.y = {a_item.corner3_y, a_item.corner2_y, a_item.corner1_y, a_item.corner0_y};
    b_geo_next.tri_shape = corner_count == scl_pkg::CC_TRIANGLE;
    b_geo_next.zero_vel  = (a_item.velocity_x == '0) && (a_item.velocity_y == '0);
    for (int e = 0; e < NC; e++) begin
      nxt = e + 1;
      if (e == NC - 1 || (e == scl_pkg::TRI_CLOSE_EDGE && b_geo_next.tri_shape)) begin
        nxt = 0;
      end
      b_geo_next.ex[e] = sdiff(b_geo_next.x[nxt], b_geo_next.x[e]);
      b_geo_next.ey[e] = sdiff(b_geo_next.y[nxt], b_geo_next.y[e]);
      b_rx_next[e]     = sdiff(b_geo_next.x[e], a_item.point_x);
      b_ry_next[e]     = sdiff(b_geo_next.y[e], a_item.point_y);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_geo <= b_geo_next;
      b_rx  <= b_rx_next;
      b_ry  <= b_ry_next;
      b_vx  <= a_item.velocity_x;
      b_vy  <= a_item.velocity_y;
    end
  end

  // stage C: cross products
  scl_pkg::geo_t         c_geo;
  logic [NC-1:0][PW-1:0] c_pd1, c_pd2, c_pn1, c_pn2;

  always_ff @(posedge clk) begin
    if (en) begin
      c_geo <= b_geo;
      for (int e = 0; e < NC; e++) begin
        c_pd1[e] <= $signed(b_geo.ex[e]) * $signed({b_vy[W-1], b_vy});
        c_pd2[e] <= $signed(b_geo.ey[e]) * $signed({b_vx[W-1], b_vx});
        c_pn1[e] <= $signed(b_ry[e]) * $signed({b_vx[W-1], b_vx});
        c_pn2[e] <= $signed(b_rx[e]) * $signed({b_vy[W-1], b_vy});
      end
    end
  end

  // stage D: denominator and numerator of the edge parameter
  scl_pkg::geo_t         d_geo;
  logic [NC-1:0][PW-1:0] d_den, d_num;

  always_ff @(posedge clk) begin
    if (en) begin
      d_geo <= c_geo;
      for (int e = 0; e < NC; e++) begin
        d_den[e] <= $signed(c_pd1[e]) - $signed(c_pd2[e]);
        d_num[e] <= $signed(c_pn1[e]) - $signed(c_pn2[e]);
      end
    end
  end

  // stage E: cut test without dividing, then positive denominator
  scl_pkg::geo_t         e_geo;
  logic [NC-1:0][RW-1:0] e_den, e_num;
  logic [NC-1:0]         e_ok, e_ok_next;

  always_comb begin
    logic den_neg, num_neg, in_range;
    for (int e = 0; e < NC; e++) begin
      den_neg = d_den[e][PW-1];
      num_neg = d_num[e][PW-1];
      if (den_neg) begin
        in_range = (num_neg || d_num[e] == '0) && ($signed(d_num[e]) >= $signed(d_den[e]));
      end else begin
        in_range = !num_neg && ($signed(d_num[e]) <= $signed(d_den[e]));
      end
      e_ok_next[e] = (d_den[e] != '0) && in_range && (e != NC - 1 || !d_geo.tri_shape);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_geo <= d_geo;
      e_ok  <= e_ok_next;
      for (int e = 0; e < NC; e++) begin
        e_den[e] <= d_den[e][PW-1] ? RW'(-d_den[e]) : d_den[e][RW-1:0];
        e_num[e] <= d_den[e][PW-1] ? RW'(-d_num[e]) : d_num[e][RW-1:0];
      end
    end
  end

  // stage F: first two cuts in edge order, or stand-in points for zero velocity and no cuts
  scl_pkg::cut_t [NK-1:0] f_cut_next, f_cut;
  scl_pkg::status_t       f_status_next, f_status;
  logic [RW-1:0]          one_den;

  assign one_den = {{(RW-1){1'b0}}, 1'b1};

  always_comb begin
    logic [1:0] cnt;
    logic [1:0] k0, k1;
    cnt = '0;
    k0  = '0;
    k1  = '0;
    for (int e = 0; e < NC; e++) begin
      if (e_ok[e]) begin
        if (cnt == 2'd0) begin
          k0 = 2'(e);
        end else if (cnt == 2'd1) begin
          k1 = 2'(e);
        end
        if (cnt != 2'd2) begin
          cnt = cnt + 2'd1;
        end
      end
    end
    if (e_geo.zero_vel) begin
      // zero offsets turn the cut points into corners 0 and 2
      f_status_next = scl_pkg::STATUS_ZERO_VEL;
      f_cut_next[0] = make_cut('0, one_den, '0, '0, e_geo.x[0], e_geo.y[0]);
      f_cut_next[1] = make_cut('0, one_den, '0, '0, e_geo.x[2], e_geo.y[2]);
    end else if (cnt != 2'd2) begin
      f_status_next = scl_pkg::STATUS_NO_CUTS;
      f_cut_next[0] = make_cut('0, one_den, '0, '0, e_geo.x[0], e_geo.y[0]);
      f_cut_next[1] = f_cut_next[0];
    end else begin
      f_status_next = scl_pkg::STATUS_TWO_CUTS;
      f_cut_next[0] = make_cut(e_num[k0], e_den[k0], e_geo.ex[k0], e_geo.ey[k0],
                               e_geo.x[k0], e_geo.y[k0]);
      f_cut_next[1] = make_cut(e_num[k1], e_den[k1], e_geo.ex[k1], e_geo.ey[k1],
                               e_geo.x[k1], e_geo.y[k1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_cut    <= f_cut_next;
      f_status <= f_status_next;
    end
  end

  // stage G: partial products of numerator times edge
  logic [NK-1:0][2*W-1:0]     g_plx, g_ply;
  logic [NK-1:0][RW-1:0]      g_phx, g_phy, g_den;
  scl_pkg::cut_side_t [NK-1:0] g_side;
  scl_pkg::status_t            g_status;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NK; c++) begin
        g_plx[c]  <= f_cut[c].num[W-1:0] * f_cut[c].absx;
        g_ply[c]  <= f_cut[c].num[W-1:0] * f_cut[c].absy;
        g_phx[c]  <= f_cut[c].num[RW-1:W] * f_cut[c].absx;
        g_phy[c]  <= f_cut[c].num[RW-1:W] * f_cut[c].absy;
        g_den[c]  <= f_cut[c].den;
        g_side[c] <= f_cut[c].side;
      end
      g_status <= f_status;
    end
  end

  // stage H: full products
  logic [NK-1:0][XW-1:0]       h_mx, h_my;
  logic [NK-1:0][RW-1:0]       h_den;
  scl_pkg::div_side_t          h_side;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NK; c++) begin
        h_mx[c]  <= {g_phx[c], {W{1'b0}}} + {{(XW-2*W){1'b0}}, g_plx[c]};
        h_my[c]  <= {g_phy[c], {W{1'b0}}} + {{(XW-2*W){1'b0}}, g_ply[c]};
        h_den[c] <= g_den[c];
      end
      h_side.cs     <= g_side;
      h_side.status <= g_status;
    end
  end

  // quotient dividers with matching delay line for the side data
  logic [NK-1:0][W-1:0] qx, qy;
  logic [NK-1:0]        rx_up, ry_up;
  scl_pkg::div_side_t   dsd [scl_pkg::DIV_STEPS];

  for (genvar c = 0; c < NK; c++) begin : g_cut
    scl_div u_div_x (
      .clk      (clk),
      .en       (en),
      .dividend (h_mx[c]),
      .divisor  (h_den[c]),
      .quotient (qx[c]),
      .round_up (rx_up[c])
    );
    scl_div u_div_y (
      .clk      (clk),
      .en       (en),
      .dividend (h_my[c]),
      .divisor  (h_den[c]),
      .quotient (qy[c]),
      .round_up (ry_up[c])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsd[0] <= h_side;
      for (int i = 1; i < scl_pkg::DIV_STEPS; i++) begin
        dsd[i] <= dsd[i-1];
      end
    end
  end

  // stage R: rounded offset added to the edge start
  logic [NK-1:0][W-1:0] r_cx, r_cy;
  scl_pkg::status_t     r_status;
  scl_pkg::div_side_t   dlast;

  assign dlast = dsd[scl_pkg::DIV_STEPS-1];

  always_ff @(posedge clk) begin
    logic [W:0]   qrx, qry;
    logic [W+1:0] sx, sy;
    if (en) begin
      for (int c = 0; c < NK; c++) begin
        qrx = {1'b0, qx[c]} + {{W{1'b0}}, rx_up[c]};
        qry = {1'b0, qy[c]} + {{W{1'b0}}, ry_up[c]};
        sx = {{2{dlast.cs[c].basex[W-1]}}, dlast.cs[c].basex}
           + (dlast.cs[c].negx ? -{1'b0, qrx} : {1'b0, qrx});
        sy = {{2{dlast.cs[c].basey[W-1]}}, dlast.cs[c].basey}
           + (dlast.cs[c].negy ? -{1'b0, qry} : {1'b0, qry});
        // the cut lies on its edge, so it fits the coordinate word
        r_cx[c] <= sx[W-1:0];
        r_cy[c] <= sy[W-1:0];
      end
      r_status <= dlast.status;
    end
  end

  // stage S: chord components
  logic [W-1:0]     s_ax, s_ay;
  scl_pkg::status_t s_status;

  always_ff @(posedge clk) begin
    if (en) begin
      s_ax     <= mag(sdiff(r_cx[1], r_cx[0]));
      s_ay     <= mag(sdiff(r_cy[1], r_cy[0]));
      s_status <= r_status;
    end
  end

  // stage T: squares
  logic [2*W-1:0]   t_sx, t_sy;
  scl_pkg::status_t t_status;

  always_ff @(posedge clk) begin
    if (en) begin
      t_sx     <= s_ax * s_ax;
      t_sy     <= s_ay * s_ay;
      t_status <= s_status;
    end
  end

  // stage U: sum of squares
  logic [scl_pkg::SQ_W-1:0] u_sum;
  scl_pkg::status_t         u_status;

  always_ff @(posedge clk) begin
    if (en) begin
      u_sum    <= {1'b0, t_sx} + {1'b0, t_sy};
      u_status <= t_status;
    end
  end

  // square root with status delay line
  logic [scl_pkg::ROOT_W-1:0] root;
  logic                       root_up;
  scl_pkg::status_t           ssd [scl_pkg::SQRT_STEPS];

  scl_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (u_sum),
    .root     (root),
    .round_up (root_up)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ssd[0] <= u_status;
      for (int i = 1; i < scl_pkg::SQRT_STEPS; i++) begin
        ssd[i] <= ssd[i-1];
      end
    end
  end

  // stage V: rounding, saturation, zero length for no cuts, output register
  scl_pkg::out_item_t          o_item;
  logic [scl_pkg::ROOT_W:0]    len;
  scl_pkg::status_t            v_status;

  assign v_status = ssd[scl_pkg::SQRT_STEPS-1];
  assign len      = {1'b0, root} + {{scl_pkg::ROOT_W{1'b0}}, root_up};

  always_ff @(posedge clk) begin
    if (en) begin
      o_item.status <= v_status;
      if (v_status == scl_pkg::STATUS_NO_CUTS) begin
        o_item.chord_length <= '0;
      end else if (len[scl_pkg::ROOT_W:W] != '0) begin
        o_item.chord_length <= '1;
      end else begin
        o_item.chord_length <= len[W-1:0];
      end
    end
  end

  assign result.data = o_item;

endmodule

// ----- rtl/scl_checker.sv -----
// port-level assertions for the streamline chord length unit, bound to the top level
// depends on scl_pkg for the status codes
module scl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          query_ready,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic [scl_pkg::WORD_BITS-1:0] chord_length,
  input scl_pkg::status_t              status
);

  // nothing comes out during or right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat after reset");

  // an empty output stage never blocks the query side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> query_ready)
    else $error("query blocked with empty output");

  // a failed query always reports zero length
  a_no_cut_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == scl_pkg::STATUS_NO_CUTS) |-> chord_length == '0)
    else $error("nonzero length without two cuts");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(chord_length) && $stable(status)))
    else $error("stalled result beat changed");

endmodule

bind streamline_chord_length_unit scl_checker u_scl_checker (
  .clk          (clk),
  .rst          (rst),
  .query_ready  (query.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .chord_length (result.data.chord_length),
  .status       (result.data.status)
);

// ----- tb/streamline_chord_length_unit_tb.sv -----
// testbench for streamline_chord_length_unit: directed and random element queries
// against an exact integer predictor; depends on scl_pkg, scl_if and the rtl top
`timescale 1ns / 1ps

module streamline_chord_length_unit_tb;

  typedef logic signed [127:0] wide_t;

  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] HALF = 32'h0000_8000;
  localparam logic [31:0] MAXW = 32'h7FFF_FFFF;
  localparam logic [31:0] MINW = 32'h8000_0000;

  logic clk;
  logic rst;

  scl_cfg_if cfg_if ();
  scl_in_if  query_if ();
  scl_out_if result_if ();

  streamline_chord_length_unit uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_if),
    .query  (query_if),
    .result (result_if)
  );

  scl_pkg::in_item_t  pending_q[$];
  scl_pkg::out_item_t chord_q[$];
  logic [scl_pkg::CC_W-1:0] shape_reg;
  int errors;
  int results_seen;
  int status_count[3];
  int burst_left;
  int gap_left;
  int pattern_mode;
  int pattern_cyc;
  logic hold_off;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic wide_t widen(logic [31:0] w);
    return {{96{w[31]}}, w};
  endfunction

  // round(num * e / den) with ties away from zero, den positive
  function automatic wide_t edge_offset(wide_t num, wide_t e, wide_t den);
    wide_t p, m, q;
    p = num * e;
    m = (p < 0) ? -p : p;
    q = (2 * m + den) / (2 * den);
    return (p < 0) ? -q : q;
  endfunction

  function automatic wide_t root_nearest(wide_t s);
    wide_t r, c, one;
    one = 1;
    r = 0;
    for (int i = 40; i >= 0; i--) begin
      c = r | (one << i);
      if (c * c <= s) r = c;
    end
    if (s - r * r > r) r = r + 1;
    return r;
  endfunction

  function automatic scl_pkg::out_item_t chord_of(scl_pkg::in_item_t q,
                                                  logic [scl_pkg::CC_W-1:0] shape);
    wide_t x[4], y[4], cxs[2], cys[2];
    wide_t gx, gy, vx, vy, dx, dy, ex, ey, den, num, len, word_max;
    int n, j, cuts;
    scl_pkg::out_item_t r;
    x[0] = widen(q.corner0_x); y[0] = widen(q.corner0_y);
    x[1] = widen(q.corner1_x); y[1] = widen(q.corner1_y);
    x[2] = widen(q.corner2_x); y[2] = widen(q.corner2_y);
    x[3] = widen(q.corner3_x); y[3] = widen(q.corner3_y);
    gx = widen(q.point_x); gy = widen(q.point_y);
    vx = widen(q.velocity_x); vy = widen(q.velocity_y);
    word_max = {96'b0, 32'hFFFF_FFFF};
    n = (shape == scl_pkg::CC_TRIANGLE) ? 3 : 4;
    cuts = 0;
    if (vx == 0 && vy == 0) begin
      dx = x[2] - x[0];
      dy = y[2] - y[0];
      r.status = scl_pkg::STATUS_ZERO_VEL;
    end else begin
      for (int k = 0; k < n; k++) begin
        if (cuts < 2) begin
          j = (k + 1 == n) ? 0 : k + 1;
          ex = x[j] - x[k];
          ey = y[j] - y[k];
          den = ex * vy - ey * vx;
          num = (y[k] - gy) * vx - (x[k] - gx) * vy;
          if (den != 0) begin
            if (den < 0) begin
              den = -den;
              num = -num;
            end
            if (num >= 0 && num <= den) begin
              cxs[cuts] = x[k] + edge_offset(num, ex, den);
              cys[cuts] = y[k] + edge_offset(num, ey, den);
              cuts++;
            end
          end
        end
      end
      if (cuts < 2) begin
        r.chord_length = '0;
        r.status = scl_pkg::STATUS_NO_CUTS;
        return r;
      end
      dx = cxs[1] - cxs[0];
      dy = cys[1] - cys[0];
      r.status = scl_pkg::STATUS_TWO_CUTS;
    end
    len = root_nearest(dx * dx + dy * dy);
    r.chord_length = (len > word_max) ? '1 : len[31:0];
    return r;
  endfunction

  function automatic scl_pkg::in_item_t mk(logic [31:0] c0x, c0y, c1x, c1y, c2x, c2y,
                                           c3x, c3y, logic [31:0] px, py, vx, vy);
    scl_pkg::in_item_t q;
    q.corner0_x = c0x; q.corner0_y = c0y; q.corner1_x = c1x; q.corner1_y = c1y;
    q.corner2_x = c2x; q.corner2_y = c2y; q.corner3_x = c3x; q.corner3_y = c3y;
    q.point_x = px; q.point_y = py; q.velocity_x = vx; q.velocity_y = vy;
    return q;
  endfunction

  function automatic int pm(int m);
    return $signed($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic scl_pkg::in_item_t rand_query();
    scl_pkg::in_item_t q;
    int kind, a, b, cx, cy, vk, sh;
    q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    kind = $urandom_range(0, 99);
    if (kind < 12) return q;
    a = $urandom_range(1, 1 << $urandom_range(2, 26));
    b = $urandom_range(1, 1 << $urandom_range(2, 26));
    cx = $signed($urandom) >>> $urandom_range(3, 14);
    cy = $signed($urandom) >>> $urandom_range(3, 14);
    q.corner0_x = cx - a + pm(a / 4); q.corner0_y = cy - b + pm(b / 4);
    q.corner1_x = cx + a + pm(a / 4); q.corner1_y = cy - b + pm(b / 4);
    q.corner2_x = cx + a + pm(a / 4); q.corner2_y = cy + b + pm(b / 4);
    q.corner3_x = cx - a + pm(a / 4); q.corner3_y = cy + b + pm(b / 4);
    if (kind < 22) begin
      // line through a corner
      case ($urandom_range(0, 3))
        0: begin q.point_x = q.corner0_x; q.point_y = q.corner0_y; end
        1: begin q.point_x = q.corner1_x; q.point_y = q.corner1_y; end
        2: begin q.point_x = q.corner2_x; q.point_y = q.corner2_y; end
        default: begin q.point_x = q.corner3_x; q.point_y = q.corner3_y; end
      endcase
    end else if (kind < 30) begin
      q.point_x = cx + pm(a) * 3;
      q.point_y = cy + pm(b) * 3;
    end else begin
      q.point_x = cx + pm(a / 2);
      q.point_y = cy + pm(b / 2);
    end
    vk = $urandom_range(0, 9);
    sh = $urandom_range(1, 30);
    case (vk)
      0: begin q.velocity_x = '0; q.velocity_y = '0; end
      1: begin q.velocity_x = pm(1 << sh); q.velocity_y = '0; end
      2: begin q.velocity_x = '0; q.velocity_y = pm(1 << sh); end
      3: ;
      default: begin q.velocity_x = pm(1 << sh); q.velocity_y = pm(1 << sh); end
    endcase
    return q;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %0s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // sender: bursts with gaps, holds the beat while the block stalls
  always @(posedge clk) begin
    if (rst) begin
      query_if.valid <= 1'b0;
      query_if.data  <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (query_if.valid && query_if.ready) begin
        chord_q.push_back(chord_of(pending_q[0], shape_reg));
        pending_q.pop_front();
      end
      if (query_if.valid && !query_if.ready) begin
        // hold
      end else if (gap_left > 0) begin
        gap_left--;
        query_if.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        query_if.valid <= 1'b1;
        query_if.data  <= pending_q[0];
        if (burst_left == 0) burst_left = $urandom_range(1, 60);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        query_if.valid <= 1'b0;
      end
    end
  end

  // receiver: switches between randomly chosen stall patterns, all gated by the hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
      pattern_mode = 0;
      pattern_cyc = 0;
    end else begin
      pattern_cyc++;
      if (pattern_cyc % 200 == 0) pattern_mode = $urandom_range(0, 3);
      case (pattern_mode)
        0: result_if.ready <= !hold_off;
        1: result_if.ready <= !hold_off && ($urandom_range(0, 3) != 0);
        2: result_if.ready <= !hold_off && ((pattern_cyc % 16) < 5);
        default: result_if.ready <= !hold_off && ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (chord_q.size() == 0) begin
        report_mismatch("unexpected beat", result_if.data.chord_length, '0);
      end else begin
        if (result_if.data.chord_length !== chord_q[0].chord_length)
          report_mismatch("chord_length", result_if.data.chord_length,
                          chord_q[0].chord_length);
        if (result_if.data.status !== chord_q[0].status)
          report_mismatch("status", 32'(result_if.data.status), 32'(chord_q[0].status));
        if (chord_q[0].status <= scl_pkg::STATUS_NO_CUTS) status_count[chord_q[0].status]++;
        results_seen++;
        chord_q.pop_front();
      end
    end
  end

  // long receiver hold-off so the pipeline fills and backs up the input
  initial begin
    hold_off = 1'b0;
    @(negedge rst);
    repeat (100) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #3000000;
    $display("timeout with %0d beats still expected", chord_q.size() + pending_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  task automatic wait_idle();
    while (pending_q.size() > 0 || chord_q.size() > 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  task automatic write_shape(logic [scl_pkg::CC_W-1:0] v);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    shape_reg = v;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic push_directed();
    // unit square, horizontal line through the middle
    pending_q.push_back(mk(0, 0, ONE, 0, ONE, ONE, 0, ONE, HALF, HALF, ONE, 0));
    // diagonal through two corners
    pending_q.push_back(mk(0, 0, ONE, 0, ONE, ONE, 0, ONE, HALF, HALF, ONE, ONE));
    // line outside the element
    pending_q.push_back(mk(0, 0, ONE, 0, ONE, ONE, 0, ONE, HALF, 2 * ONE, ONE, 0));
    // line along an edge, parallel edges skipped
    pending_q.push_back(mk(0, 0, ONE, 0, ONE, ONE, 0, ONE, HALF, 0, ONE, 0));
    // through corner 1 only
    pending_q.push_back(mk(0, 0, ONE, 0, ONE, ONE, 0, ONE, ONE, 0, ONE, ONE));
    // vertical and tiny velocity
    pending_q.push_back(mk(0, 0, ONE, 0, ONE, ONE, 0, ONE, HALF, HALF, 0, ONE));
    pending_q.push_back(mk(0, 0, ONE, 0, ONE, ONE, 0, ONE, HALF, HALF, 1, 32'hFFFF_FFFF));
    // zero velocity, saturating corner distance
    pending_q.push_back(mk(MINW, MINW, 0, 0, MAXW, MAXW, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW,
                           MAXW, MAXW, MAXW, MAXW));
    pending_q.push_back(mk(MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW,
                           MINW, MINW, MINW, MINW));
    pending_q.push_back('1);
    // huge element, extreme velocity, long chord
    pending_q.push_back(mk(MINW, MINW, MAXW, MINW, MAXW, MAXW, MINW, MAXW,
                           0, 0, MINW, MINW));
    pending_q.push_back(mk(MINW, MINW, MAXW, MINW, MAXW, MAXW, MINW, MAXW,
                           0, 0, MAXW, 0));
    pending_q.push_back(mk(MINW, 0, MAXW, 0, MAXW, MAXW, MINW, MAXW, 0, HALF, MAXW, 1));
    // degenerate element, all corners equal
    pending_q.push_back(mk(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, 0));
  endtask

  task automatic push_random(int count);
    for (int i = 0; i < count; i++) pending_q.push_back(rand_query());
  endtask

  initial begin
    rst = 1'b1;
    errors = 0;
    results_seen = 0;
    status_count = '{0, 0, 0};
    shape_reg = scl_pkg::CC_RESET;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    query_if.valid = 1'b0;
    query_if.data = '0;
    result_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_directed();
    push_random(300);
    write_shape(scl_pkg::CC_TRIANGLE);
    push_directed();
    push_random(180);
    write_shape(3'd7);
    push_random(100);
    write_shape(3'd0);
    push_random(100);
    write_shape(3'd4);
    push_random(100);
    write_shape(scl_pkg::CC_TRIANGLE);
    push_random(70);
    wait_idle();

    $display("%0d results checked over triangle and quadrilateral shapes", results_seen);
    $display("two cuts %0d, zero velocity %0d, no cuts %0d",
             status_count[0], status_count[1], status_count[2]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
